FILE: hdl/tkms_pkg.sv
`timescale 1ns / 1ps

package tkms_pkg;

  localparam int VAL_W        = 32;
  localparam int IDX_W        = 24;
  localparam int LIMIT_W      = 10;
  localparam int CAPACITY_DEF = 1024;

  localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST = LIMIT_W'(1000);

  // operation codes on in_func
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [IDX_W-1:0] index;
  } entry_t;

endpackage

FILE: hdl/tkms_cmp.sv
`timescale 1ns / 1ps

// Heap order: magnitude, then index, then signed value.
module tkms_cmp (
  input  tkms_pkg::entry_t a,
  input  tkms_pkg::entry_t b,
  output logic             a_below
);

  function automatic logic [tkms_pkg::VAL_W-1:0] magnitude(
    input logic signed [tkms_pkg::VAL_W-1:0] v
  );
    logic [tkms_pkg::VAL_W-1:0] u;
    begin
      u = v;
      if (!u[tkms_pkg::VAL_W-1]) begin
        magnitude = u;
      end else if (u == {1'b1, {(tkms_pkg::VAL_W-1){1'b0}}}) begin
        // most negative value saturates
        magnitude = {1'b0, {(tkms_pkg::VAL_W-1){1'b1}}};
      end else begin
        magnitude = ~u + 1'b1;
      end
    end
  endfunction

  logic [tkms_pkg::VAL_W-1:0] mag_a;
  logic [tkms_pkg::VAL_W-1:0] mag_b;

  assign mag_a = magnitude(a.value);
  assign mag_b = magnitude(b.value);

  always_comb begin
    if (mag_a != mag_b) begin
      a_below = mag_a < mag_b;
    end else if (a.index != b.index) begin
      a_below = a.index < b.index;
    end else begin
      a_below = a.value < b.value;
    end
  end

endmodule

FILE: hdl/top_k_magnitude_selector_core.sv
`timescale 1ns / 1ps

// Push: busy through the sift-up (one heap level a cycle); when the
//   store then exceeds keep_limit, busy stays high for the discard and sift-down.
// Pop: the root is read, then ST_POP_OUT registers the result strobe (an empty
//   store answers from ST_IDLE); busy lasts through the sift-down. One heap RAM
//   port pair and one shared comparator serve all steps. Results cannot be stalled.
// Reset: synchronous, empties the store and sets keep_limit to 1000.
module top_k_magnitude_selector_core #(
  parameter int CAPACITY = tkms_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic signed [tkms_pkg::VAL_W-1:0]  in_coeff_value,
  input  logic        [tkms_pkg::IDX_W-1:0]  in_item_index,
  output logic                               out_valid,
  output logic signed [tkms_pkg::VAL_W-1:0]  out_value,
  output logic        [tkms_pkg::IDX_W-1:0]  out_index,
  output logic                               out_was_empty,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [tkms_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CNW = AW + 1;
  localparam int CHW = AW + 2;
  localparam int LW  = (CNW > tkms_pkg::LIMIT_W) ? CNW : tkms_pkg::LIMIT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PU_CMP,
    ST_POP_OUT,
    ST_RM_START,
    ST_RM_LOAD,
    ST_SD_RDR,
    ST_SD_CMP,
    ST_SD_DEC,
    ST_WR_X
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                  pos_r, pos_nxt;
  tkms_pkg::entry_t               x_r, x_nxt;
  tkms_pkg::entry_t               best_r, best_nxt;
  logic                           best_child_r, best_child_nxt;
  logic                           up_r, up_nxt;
  logic [tkms_pkg::LIMIT_W-1:0]   limit_r;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [tkms_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic [tkms_pkg::IDX_W-1:0]     out_index_r, out_index_nxt;
  logic                           out_empty_r, out_empty_nxt;

  // heap RAM
  tkms_pkg::entry_t               mem [CAPACITY];
  tkms_pkg::entry_t               rd_r;
  logic                           mem_we;
  logic [AW-1:0]                  mem_wa;
  logic [AW-1:0]                  mem_ra;
  tkms_pkg::entry_t               mem_wd;

  // shared comparator
  tkms_pkg::entry_t               cmp_a, cmp_b;
  logic                           cmp_below;

  logic [AW-1:0]                  parent_pos;
  logic [AW-1:0]                  gparent_pos;
  logic [CHW-1:0]                 l_ext, r_ext, cnt_ext, nl_ext;
  logic [CNW-1:0]                 cnt_dec;
  logic [LW-1:0]                  lim_eff;
  logic                           over_limit;
  logic                           take_l, take_r;
  logic [AW-1:0]                  child_pos;
  tkms_pkg::entry_t               child_data;

  tkms_cmp u_cmp (
    .a       (cmp_a),
    .b       (cmp_b),
    .a_below (cmp_below)
  );

  assign parent_pos  = (pos_r - AW'(1)) >> 1;
  assign gparent_pos = (parent_pos - AW'(1)) >> 1;
  assign l_ext       = {1'b0, pos_r, 1'b1};
  assign r_ext       = l_ext + CHW'(1);
  assign cnt_ext     = CHW'(count_r);
  assign cnt_dec     = count_r - CNW'(1);
  assign lim_eff     = (LW'(limit_r) > LW'(CAPACITY - 1)) ? LW'(CAPACITY - 1)
                                                          : LW'(limit_r);
  assign over_limit  = LW'(count_r) > lim_eff;
  assign child_pos   = take_r ? r_ext[AW-1:0] : l_ext[AW-1:0];
  assign child_data  = take_r ? rd_r : best_r;
  assign nl_ext      = {1'b0, child_pos, 1'b1};

  always_comb begin
    case (state_r)
      ST_PU_CMP: begin
        cmp_a = x_r;
        cmp_b = rd_r;
      end
      ST_SD_RDR: begin
        cmp_a = rd_r;
        cmp_b = x_r;
      end
      default: begin
        cmp_a = rd_r;
        cmp_b = best_r;
      end
    endcase
  end

  always_comb begin
    take_r = 1'b0;
    take_l = 1'b0;
    case (state_r)
      ST_SD_CMP: begin
        take_r = cmp_below;
        take_l = !cmp_below && best_child_r;
      end
      ST_SD_DEC: begin
        take_l = best_child_r;
      end
      default: begin
        take_r = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    x_nxt          = x_r;
    best_nxt       = best_r;
    best_child_nxt = best_child_r;
    up_nxt         = up_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_index_nxt  = out_index_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = x_r;
    mem_ra         = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_func == tkms_pkg::FUNC_PUSH) begin
            x_nxt.value = in_coeff_value;
            x_nxt.index = in_item_index;
            pos_nxt     = count_r[AW-1:0];
            count_nxt   = count_r + CNW'(1);
            up_nxt      = 1'b1;
            if (count_r == '0) begin
              state_nxt = ST_WR_X;
            end else begin
              mem_ra    = AW'(cnt_dec >> 1);
              state_nxt = ST_PU_CMP;
            end
          end else if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_index_nxt = '0;
            out_empty_nxt = 1'b1;
          end else begin
            // root is being read this cycle
            state_nxt = ST_POP_OUT;
          end
        end
      end

      ST_PU_CMP: begin
        if (cmp_below) begin
          // move parent down into the hole
          mem_we  = 1'b1;
          mem_wd  = rd_r;
          pos_nxt = parent_pos;
          if (parent_pos == '0) begin
            state_nxt = ST_WR_X;
          end else begin
            mem_ra = gparent_pos;
          end
        end else begin
          state_nxt = ST_WR_X;
        end
      end

      ST_POP_OUT, ST_RM_START: begin
        if (state_r == ST_POP_OUT) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_r.value;
          out_index_nxt = rd_r.index;
          out_empty_nxt = 1'b0;
        end
        count_nxt = cnt_dec;
        up_nxt    = 1'b0;
        if (cnt_dec == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          mem_ra    = cnt_dec[AW-1:0];
          state_nxt = ST_RM_LOAD;
        end
      end

      ST_RM_LOAD: begin
        // last entry becomes the item to sift down from the root
        x_nxt   = rd_r;
        pos_nxt = '0;
        if (count_r > CNW'(1)) begin
          mem_ra    = AW'(1);
          state_nxt = ST_SD_RDR;
        end else begin
          state_nxt = ST_WR_X;
        end
      end

      ST_SD_RDR: begin
        best_nxt       = cmp_below ? rd_r : x_r;
        best_child_nxt = cmp_below;
        if (r_ext < cnt_ext) begin
          mem_ra    = r_ext[AW-1:0];
          state_nxt = ST_SD_CMP;
        end else begin
          state_nxt = ST_SD_DEC;
        end
      end

      ST_SD_CMP, ST_SD_DEC: begin
        if (take_r || take_l) begin
          mem_we  = 1'b1;
          mem_wd  = child_data;
          pos_nxt = child_pos;
          if (nl_ext < cnt_ext) begin
            mem_ra    = nl_ext[AW-1:0];
            state_nxt = ST_SD_RDR;
          end else begin
            state_nxt = ST_WR_X;
          end
        end else begin
          state_nxt = ST_WR_X;
        end
      end

      ST_WR_X: begin
        mem_we = 1'b1;
        up_nxt = 1'b0;
        if (up_r && over_limit) begin
          state_nxt = ST_RM_START;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      up_r         <= 1'b0;
      limit_r      <= tkms_pkg::KEEP_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      up_r         <= up_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
    pos_r        <= pos_nxt;
    x_r          <= x_nxt;
    best_r       <= best_nxt;
    best_child_r <= best_child_nxt;
    out_value_r  <= out_value_nxt;
    out_index_r  <= out_index_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[mem_ra];
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_index     = out_index_r;
  assign out_was_empty = out_empty_r;

endmodule

FILE: hdl/tkms_checker.sv
`timescale 1ns / 1ps

module tkms_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_func,
  input logic                               out_valid,
  input logic signed [tkms_pkg::VAL_W-1:0]  out_value,
  input logic        [tkms_pkg::IDX_W-1:0]  out_index,
  input logic                               out_was_empty
);

  logic acc_pop;
  logic acc_push;

  assign acc_pop  = start && !busy && (in_func == tkms_pkg::FUNC_POP);
  assign acc_push = start && !busy && (in_func == tkms_pkg::FUNC_PUSH);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

  a_strobe_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_pop) || $past(acc_pop, 2))
    else $error("result strobe without a pop transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_empty |-> out_value == '0 && out_index == '0)
    else $error("empty result carries data");

  a_pop_answers: assert property (@(posedge clk) disable iff (!rst_n)
    acc_pop |=> out_valid || busy)
    else $error("pop transfer dropped");

  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc_push |=> busy && !out_valid)
    else $error("push produced a result or no work");

endmodule

bind top_k_magnitude_selector_core tkms_checker u_tkms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_value     (out_value),
  .out_index     (out_index),
  .out_was_empty (out_was_empty)
);

FILE: tb/top_k_magnitude_selector_core_tb.sv
`timescale 1ns / 1ps

module top_k_magnitude_selector_core_tb;
  import tkms_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_LIMIT    = 4000;
  localparam int QUIET_TAIL    = 150;
  localparam int MAX_REPORTS   = 40;
  localparam int PHASE_OPS     = 88;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [IDX_W-1:0]        IDX_MAX = '1;
  localparam logic [LIMIT_W-1:0]      LIMIT_MAX = '1;

  typedef enum logic [1:0] {STEP_OP, STEP_CFG, STEP_HOLD} step_kind_e;

  typedef struct {
    step_kind_e              kind;
    logic                    func;
    logic signed [VAL_W-1:0] value;
    logic        [IDX_W-1:0] index;
    logic      [LIMIT_W-1:0] limit;
  } step_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic        [IDX_W-1:0] index;
    logic                    was_empty;
  } pop_result_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic                        in_func = FUNC_PUSH;
  logic signed [VAL_W-1:0]     in_coeff_value = '0;
  logic        [IDX_W-1:0]     in_item_index = '0;
  logic                        out_valid;
  logic signed [VAL_W-1:0]     out_value;
  logic        [IDX_W-1:0]     out_index;
  logic                        out_was_empty;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic        [LIMIT_W-1:0]   cfg_data = '0;

  step_t        pending_steps[$];
  entry_t       kept_entries[$];   // predicted store, ascending order
  pop_result_t  pops_due[$];
  pop_result_t  pop_want;
  step_t        cur_step;
  logic [LIMIT_W-1:0] keep_limit_model = KEEP_LIMIT_RST;
  logic         nxt_start, nxt_cfg_valid;

  int gap_left, settle_count, idle_cycles;
  int fail_count, pushes_done, pops_done, empty_pops, discards, results_seen, cfg_writes;

  top_k_magnitude_selector_core #(
    .CAPACITY(CAPACITY_DEF)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_coeff_value (in_coeff_value),
    .in_item_index  (in_item_index),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_index      (out_index),
    .out_was_empty  (out_was_empty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  function automatic logic [VAL_W-1:0] magnitude_of(logic signed [VAL_W-1:0] v);
    if (v == VAL_MIN) return VAL_MAX;
    if (v < 0) return -v;
    return v;
  endfunction

  // magnitude first, then index, then signed value
  function automatic bit orders_below(entry_t a, entry_t b);
    logic [VAL_W-1:0] ma, mb;
    ma = magnitude_of(a.value);
    mb = magnitude_of(b.value);
    if (ma != mb) return ma < mb;
    if (a.index != b.index) return a.index < b.index;
    return $signed(a.value) < $signed(b.value);
  endfunction

  function automatic void apply_step(step_t s);
    entry_t      e;
    pop_result_t r;
    int          pos;
    int          limit;
    if (s.func == FUNC_PUSH) begin
      e.value = s.value;
      e.index = s.index;
      pos = 0;
      while (pos < kept_entries.size() && !orders_below(e, kept_entries[pos])) pos++;
      kept_entries.insert(pos, e);
      limit = (keep_limit_model > CAPACITY_DEF - 1) ? CAPACITY_DEF - 1 : keep_limit_model;
      if (kept_entries.size() > limit) begin
        kept_entries.delete(0);
        discards++;
      end
      pushes_done++;
    end else begin
      if (kept_entries.size() == 0) begin
        r.value = '0;
        r.index = '0;
        r.was_empty = 1'b1;
        empty_pops++;
      end else begin
        e = kept_entries[0];
        kept_entries.delete(0);
        r.value = e.value;
        r.index = e.index;
        r.was_empty = 1'b0;
      end
      pops_due.push_back(r);
      pops_done++;
    end
  endfunction

  task automatic report_mismatch(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  function automatic void add_push(logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
    step_t s;
    s.kind = STEP_OP;
    s.func = FUNC_PUSH;
    s.value = v;
    s.index = idx;
    s.limit = '0;
    pending_steps.push_back(s);
  endfunction

  // value and index fields are ignored on a pop, so drive junk there
  function automatic void add_pop();
    step_t s;
    s.kind = STEP_OP;
    s.func = FUNC_POP;
    s.value = $urandom;
    s.index = $urandom;
    s.limit = '0;
    pending_steps.push_back(s);
  endfunction

  function automatic void add_barrier(step_kind_e kind, logic [LIMIT_W-1:0] lim);
    step_t s;
    s.kind = kind;
    s.func = FUNC_PUSH;
    s.value = '0;
    s.index = '0;
    s.limit = lim;
    pending_steps.push_back(s);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1;
          3: return 0;
          4: return 1;
          default: return -1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 16)) - 8;  // crowd magnitudes to force ties
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
    return $urandom_range(0, IDX_MAX);
  endfunction

  function automatic void build_directed();
    add_pop();                       // empty store right after reset
    add_push(VAL_MIN, 5);            // saturates, ties with the max positive
    add_push(VAL_MAX, 5);
    add_push(-VAL_MAX, 5);           // same magnitude and index, sign decides
    add_push(VAL_MAX, 3);            // same magnitude, smaller index wins
    add_push(0, IDX_MAX);
    add_push(1, 0);
    add_push(-1, 0);
    add_push(-1, 0);                 // exact duplicate
    repeat (9) add_pop();            // drain in order, last one empty
    add_barrier(STEP_CFG, 0);        // zero limit: store never grows
    add_push(7, 1);
    add_push(VAL_MIN, 2);
    add_pop();
    add_barrier(STEP_CFG, 1);
    add_push(3, 9);
    add_push(-5, 4);
    add_push(2, 0);
    add_pop();
    add_pop();
  endfunction

  function automatic void build_random();
    logic [LIMIT_W-1:0] phase_limits[11];
    int n, k, m;
    phase_limits = '{LIMIT_MAX, 2, 1, 0, 16, 3, KEEP_LIMIT_RST, 64, 7, LIMIT_MAX, 5};
    foreach (phase_limits[p]) begin
      // the store is not drained between phases, so lower limits hit a full store
      add_barrier(STEP_CFG, phase_limits[p]);
      if (p == 5) add_barrier(STEP_HOLD, '0);
      n = 0;
      while (n < PHASE_OPS) begin
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(1, 24);
          m = $urandom_range(0, k + 1);
          repeat (k) add_push(rand_coeff(), rand_index());
          repeat (m) add_pop();
          n += k + m;
        end else begin
          if ($urandom_range(0, 1) == 0) add_push(rand_coeff(), rand_index());
          else add_pop();
          n++;
        end
      end
    end
    repeat (20) add_pop();
  endfunction

  // driver: one nonblocking update per control signal per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left = 0;
      settle_count = 0;
    end else begin
      nxt_start = start;
      nxt_cfg_valid = cfg_valid;
      if (start && !busy) begin
        apply_step(cur_step);
        nxt_start = 1'b0;
        if (pending_steps.size() >= QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 15);
      end
      if (cfg_valid && cfg_ready) begin
        keep_limit_model = cfg_data;
        cfg_writes++;
        nxt_cfg_valid = 1'b0;
      end
      if (pops_due.size() == 0 && !busy) settle_count++;
      else settle_count = 0;
      if (!nxt_start && !nxt_cfg_valid && pending_steps.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_steps[0].kind == STEP_OP) begin
          cur_step = pending_steps.pop_front();
          nxt_start = 1'b1;
          in_func <= cur_step.func;
          in_coeff_value <= cur_step.value;
          in_item_index <= cur_step.index;
        end else if (settle_count >= SETTLE_CYCLES) begin
          // block idle and every pop answered: safe for a limit write
          cur_step = pending_steps.pop_front();
          settle_count = 0;
          if (cur_step.kind == STEP_CFG) begin
            nxt_cfg_valid = 1'b1;
            cfg_data <= cur_step.limit;
          end
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pops_due.size() == 0) begin
        report_mismatch("unexpected result", '0, out_value);
      end else begin
        pop_want = pops_due.pop_front();
        if (out_was_empty !== pop_want.was_empty)
          report_mismatch("out_was_empty", pop_want.was_empty, out_was_empty);
        if (out_value !== pop_want.value)
          report_mismatch("out_value", pop_want.value, out_value);
        if (out_index !== pop_want.index)
          report_mismatch("out_index", pop_want.index, out_index);
      end
    end
  end

  // watchdog: cycles without any transfer or result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d pops unanswered",
               IDLE_LIMIT, pops_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_steps.size() != 0 || start || cfg_valid || pops_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d pushes (%0d discarded), %0d pops (%0d on an empty store)",
             pushes_done, discards, pops_done, empty_pops);
    $display("Checked %0d results across %0d keep_limit writes, %0d mismatches",
             results_seen, cfg_writes, fail_count);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: top_k_magnitude_selector_core.f
hdl/tkms_pkg.sv
hdl/tkms_cmp.sv
hdl/top_k_magnitude_selector_core.sv
hdl/tkms_checker.sv
tb/top_k_magnitude_selector_core_tb.sv
